FILE: rtl/core/mp3_side_info_parser_assert.svh
// Assertion macros for the side-information parser.
// Used by mp3_side_info_parser.sv; expects signals clk and rst in scope.
`ifndef MP3_SIDE_INFO_PARSER_ASSERT_SVH
`define MP3_SIDE_INFO_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/msi_pkg.sv
// Types, codes and field width table for the side-information parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package msi_pkg;

  localparam int unsigned SUBBLOCK_GAINS = 3;

  // input word, one side-information byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       single_channel;
  } in_word_t;

  typedef enum logic [3:0] {
    CODE_MDS     = 4'd0,
    CODE_SHARE   = 4'd1,
    CODE_LENGTH  = 4'd2,
    CODE_BIG     = 4'd3,
    CODE_GAIN    = 4'd4,
    CODE_COMP    = 4'd5,
    CODE_SWITCH  = 4'd6,
    CODE_TYPE    = 4'd7,
    CODE_MIXED   = 4'd8,
    CODE_TABLE   = 4'd9,
    CODE_SUBGAIN = 4'd10,
    CODE_REGION0 = 4'd11,
    CODE_REGION1 = 4'd12,
    CODE_PREFLAG = 4'd13,
    CODE_SCALE   = 4'd14,
    CODE_COUNT1  = 4'd15
  } field_code_t;

  // result word, one parsed field
  typedef struct packed {
    field_code_t field_code;
    logic        granule;
    logic        channel;
    logic [1:0]  slot;
    logic [11:0] value;
    logic        error;
    logic        last;
  } out_word_t;

  // queue entry handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       mono;
  } queue_entry_t;

  // engine status seen by the top level
  typedef struct packed {
    logic busy;
    logic halted;
  } eng_status_t;

  // parse steps; DR0/DR1/DERR emit a derived word without taking a bit
  typedef enum logic [4:0] {
    STEP_MDS     = 5'd0,
    STEP_PRIV    = 5'd1,
    STEP_SHARE   = 5'd2,
    STEP_LEN     = 5'd3,
    STEP_BIG     = 5'd4,
    STEP_GAIN    = 5'd5,
    STEP_COMP    = 5'd6,
    STEP_SWITCH  = 5'd7,
    STEP_TYPE    = 5'd8,
    STEP_MIXED   = 5'd9,
    STEP_WTABLE  = 5'd10,
    STEP_SUBGAIN = 5'd11,
    STEP_NTABLE  = 5'd12,
    STEP_R0      = 5'd13,
    STEP_R1      = 5'd14,
    STEP_PRE     = 5'd15,
    STEP_SCALE   = 5'd16,
    STEP_COUNT1  = 5'd17,
    STEP_DR0     = 5'd18,
    STEP_DR1     = 5'd19,
    STEP_DERR    = 5'd20,
    STEP_IDLE    = 5'd31
  } step_t;

  // bit count of the field parsed in a step
  function automatic logic [3:0] field_width(step_t s, logic mono);
    logic [3:0] w;
    case (s)
      STEP_MDS:     w = 4'd9;
      STEP_PRIV:    w = mono ? 4'd5 : 4'd3;
      STEP_SHARE:   w = 4'd4;
      STEP_LEN:     w = 4'd12;
      STEP_BIG:     w = 4'd9;
      STEP_GAIN:    w = 4'd8;
      STEP_COMP:    w = 4'd4;
      STEP_SWITCH:  w = 4'd1;
      STEP_TYPE:    w = 4'd2;
      STEP_MIXED:   w = 4'd1;
      STEP_WTABLE:  w = 4'd5;
      STEP_SUBGAIN: w = 4'd3;
      STEP_NTABLE:  w = 4'd5;
      STEP_R0:      w = 4'd4;
      STEP_R1:      w = 4'd3;
      default:      w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/msi_byte_queue.sv
// Front end: accepts side-information bytes and queues them for the engine.
// Depends on msi_pkg.
`default_nettype none

module msi_byte_queue
  import msi_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          push_valid,
  output logic         push_ready,
  input  in_word_t     push_word,
  output logic         pop_valid,
  input  wire          pop,
  output queue_entry_t pop_entry
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  queue_entry_t    mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;
  queue_entry_t    entry;

  // a first byte marks a restart and carries the mono flag
  always_comb begin
    entry.data_byte = push_word.data_byte;
    entry.restart   = push_word.first_byte;
    entry.mono      = push_word.single_channel;
  end

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/msi_field_engine.sv
// Back end: bit-serial side-information field parser with output register.
// Depends on msi_pkg; fed by msi_byte_queue.
`default_nettype none

module msi_field_engine
  import msi_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          q_valid,
  output logic         q_pop,
  input  queue_entry_t q_entry,
  output logic         field_valid,
  input  wire          field_ready,
  output out_word_t    field_word,
  output eng_status_t  status
);

  // current byte
  logic [7:0] cur_byte, cur_byte_next;
  logic       byte_mono, byte_mono_next;
  logic       restart, restart_next;
  logic [3:0] rem, rem_next;
  logic       busy, busy_next;

  // parse state
  step_t       step, step_next;
  logic [11:0] bit_buffer, bit_buffer_next;
  logic [3:0]  bits_held, bits_held_next;
  logic        gran, gran_next;
  logic        chan, chan_next;
  logic [1:0]  slot_num, slot_num_next;
  logic        mono, mono_next;
  logic [1:0]  block_kind, block_kind_next;
  logic        mixed_flag, mixed_flag_next;

  // state as seen by this cycle, with a pending restart folded in
  step_t       eff_step;
  logic [11:0] eff_buffer;
  logic [3:0]  eff_held;
  logic        eff_gran, eff_chan, eff_mono, eff_mixed;
  logic [1:0]  eff_slot, eff_kind;

  logic        out_free, act, drop, done, emit;
  out_word_t   emit_word;
  logic [3:0]  rem_m1, held_inc;
  logic [11:0] shifted;
  logic        cur_bit;
  logic [11:0] r0;

  assign out_free = !field_valid || field_ready;

  always_comb begin
    eff_step   = restart ? STEP_MDS : step;
    eff_buffer = restart ? '0 : bit_buffer;
    eff_held   = restart ? '0 : bits_held;
    eff_gran   = restart ? 1'b0 : gran;
    eff_chan   = restart ? 1'b0 : chan;
    eff_slot   = restart ? '0 : slot_num;
    eff_mono   = restart ? byte_mono : mono;
    eff_kind   = restart ? '0 : block_kind;
    eff_mixed  = restart ? 1'b0 : mixed_flag;
  end

  assign rem_m1   = rem - 4'd1;
  assign cur_bit  = cur_byte[rem_m1[2:0]];
  assign shifted  = {eff_buffer[10:0], cur_bit};
  assign held_inc = eff_held + 4'd1;
  assign r0       = (eff_kind == 2'd2 && !eff_mixed) ? 12'd8 : 12'd7;

  always_comb begin
    cur_byte_next   = cur_byte;
    byte_mono_next  = byte_mono;
    restart_next    = restart;
    rem_next        = rem;
    busy_next       = busy;
    step_next       = step;
    bit_buffer_next = bit_buffer;
    bits_held_next  = bits_held;
    gran_next       = gran;
    chan_next       = chan;
    slot_num_next   = slot_num;
    mono_next       = mono;
    block_kind_next = block_kind;
    mixed_flag_next = mixed_flag;
    emit            = 1'b0;
    emit_word       = '0;
    q_pop           = 1'b0;

    drop = busy && (eff_step == STEP_IDLE);
    act  = busy && out_free && (eff_step != STEP_IDLE);

    if (act) begin
      restart_next    = 1'b0;
      step_next       = eff_step;
      bit_buffer_next = eff_buffer;
      bits_held_next  = eff_held;
      gran_next       = eff_gran;
      chan_next       = eff_chan;
      slot_num_next   = eff_slot;
      mono_next       = eff_mono;
      block_kind_next = eff_kind;
      mixed_flag_next = eff_mixed;
      emit_word.granule = eff_gran;
      emit_word.channel = eff_chan;

      if (eff_step inside {STEP_DR0, STEP_DR1, STEP_DERR}) begin
        emit = 1'b1;
        case (eff_step)
          STEP_DR0: begin
            emit_word.field_code = CODE_REGION0;
            emit_word.value      = r0;
            step_next            = STEP_DR1;
          end
          STEP_DR1: begin
            emit_word.field_code = CODE_REGION1;
            emit_word.value      = 12'd20 - r0;
            step_next            = STEP_PRE;
          end
          default: begin
            // window switching with block type zero
            emit_word.field_code = CODE_TYPE;
            emit_word.error      = 1'b1;
            emit_word.last       = 1'b1;
            step_next            = STEP_IDLE;
          end
        endcase
      end else begin
        rem_next        = rem_m1;
        bit_buffer_next = shifted;
        bits_held_next  = held_inc;
        if (held_inc == field_width(eff_step, eff_mono)) begin
          bit_buffer_next = '0;
          bits_held_next  = '0;
          emit            = 1'b1;
          emit_word.value = shifted;
          case (eff_step)
            STEP_MDS: begin
              emit_word.field_code = CODE_MDS;
              step_next            = STEP_PRIV;
            end
            STEP_PRIV: begin
              emit      = 1'b0;
              chan_next = 1'b0;
              step_next = STEP_SHARE;
            end
            STEP_SHARE: begin
              emit_word.field_code = CODE_SHARE;
              if (!eff_mono && !eff_chan) begin
                chan_next = 1'b1;
              end else begin
                chan_next = 1'b0;
                gran_next = 1'b0;
                step_next = STEP_LEN;
              end
            end
            STEP_LEN: begin
              emit_word.field_code = CODE_LENGTH;
              step_next            = STEP_BIG;
            end
            STEP_BIG: begin
              emit_word.field_code = CODE_BIG;
              step_next            = STEP_GAIN;
            end
            STEP_GAIN: begin
              emit_word.field_code = CODE_GAIN;
              step_next            = STEP_COMP;
            end
            STEP_COMP: begin
              emit_word.field_code = CODE_COMP;
              step_next            = STEP_SWITCH;
            end
            STEP_SWITCH: begin
              emit_word.field_code = CODE_SWITCH;
              slot_num_next        = '0;
              if (shifted[0]) begin
                step_next = STEP_TYPE;
              end else begin
                block_kind_next = '0;
                mixed_flag_next = 1'b0;
                step_next       = STEP_NTABLE;
              end
            end
            STEP_TYPE: begin
              emit_word.field_code = CODE_TYPE;
              block_kind_next      = shifted[1:0];
              step_next            = STEP_MIXED;
            end
            STEP_MIXED: begin
              emit_word.field_code = CODE_MIXED;
              mixed_flag_next      = shifted[0];
              slot_num_next        = '0;
              step_next            = STEP_WTABLE;
            end
            STEP_WTABLE: begin
              emit_word.field_code = CODE_TABLE;
              emit_word.slot       = eff_slot;
              if (eff_slot >= 2'd1) begin
                slot_num_next = '0;
                step_next     = STEP_SUBGAIN;
              end else begin
                slot_num_next = eff_slot + 2'd1;
              end
            end
            STEP_SUBGAIN: begin
              emit_word.field_code = CODE_SUBGAIN;
              emit_word.slot       = eff_slot;
              if (eff_slot == 2'(SUBBLOCK_GAINS - 1)) begin
                slot_num_next = '0;
                step_next     = (eff_kind == 2'd0) ? STEP_DERR : STEP_DR0;
              end else begin
                slot_num_next = eff_slot + 2'd1;
              end
            end
            STEP_NTABLE: begin
              emit_word.field_code = CODE_TABLE;
              emit_word.slot       = eff_slot;
              if (eff_slot >= 2'd2) begin
                slot_num_next = '0;
                step_next     = STEP_R0;
              end else begin
                slot_num_next = eff_slot + 2'd1;
              end
            end
            STEP_R0: begin
              emit_word.field_code = CODE_REGION0;
              step_next            = STEP_R1;
            end
            STEP_R1: begin
              emit_word.field_code = CODE_REGION1;
              step_next            = STEP_PRE;
            end
            STEP_PRE: begin
              emit_word.field_code = CODE_PREFLAG;
              step_next            = STEP_SCALE;
            end
            STEP_SCALE: begin
              emit_word.field_code = CODE_SCALE;
              step_next            = STEP_COUNT1;
            end
            STEP_COUNT1: begin
              emit_word.field_code = CODE_COUNT1;
              emit_word.last       = (eff_mono || eff_chan) && eff_gran;
              if (!eff_mono && !eff_chan) begin
                chan_next = 1'b1;
                step_next = STEP_LEN;
              end else if (!eff_gran) begin
                chan_next = 1'b0;
                gran_next = 1'b1;
                step_next = STEP_LEN;
              end else begin
                step_next = STEP_IDLE;
              end
            end
            default: begin
              emit      = 1'b0;
              step_next = STEP_IDLE;
            end
          endcase
        end
      end
    end

    // byte finished once halted, or all bits in and no derived word owed
    done = drop || (act && rem_next == 4'd0 &&
                    !(step_next inside {STEP_DR0, STEP_DR1, STEP_DERR}));

    if (done) begin
      busy_next = 1'b0;
    end
    if ((!busy || done) && q_valid) begin
      q_pop          = 1'b1;
      busy_next      = 1'b1;
      cur_byte_next  = q_entry.data_byte;
      byte_mono_next = q_entry.mono;
      restart_next   = q_entry.restart;
      rem_next       = 4'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      restart     <= 1'b0;
      rem         <= '0;
      step        <= STEP_IDLE;
      bit_buffer  <= '0;
      bits_held   <= '0;
      gran        <= 1'b0;
      chan        <= 1'b0;
      slot_num    <= '0;
      mono        <= 1'b0;
      block_kind  <= '0;
      mixed_flag  <= 1'b0;
      field_valid <= 1'b0;
    end else begin
      busy        <= busy_next;
      restart     <= restart_next;
      rem         <= rem_next;
      step        <= step_next;
      bit_buffer  <= bit_buffer_next;
      bits_held   <= bits_held_next;
      gran        <= gran_next;
      chan        <= chan_next;
      slot_num    <= slot_num_next;
      mono        <= mono_next;
      block_kind  <= block_kind_next;
      mixed_flag  <= mixed_flag_next;
      if (emit) begin
        field_valid <= 1'b1;
      end else if (field_ready) begin
        field_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_byte  <= cur_byte_next;
    byte_mono <= byte_mono_next;
    if (emit) begin
      field_word <= emit_word;
    end
  end

  assign status.busy   = busy;
  assign status.halted = (step == STEP_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/mp3_side_info_parser.sv
// MPEG-1 Layer III side-information parser, top level.
// Depends on msi_pkg, msi_byte_queue, msi_field_engine and the assert header.
//
// Bytes of a frame's side information enter on the byte channel, most
// significant bit first; first_byte restarts the parse and samples
// single_channel. Every completed field leaves on the field channel as one
// word tagged with code, granule, channel and slot; private bits are
// skipped. With window switching the region counts are derived (8 for
// short blocks without mixing, else 7, and 20 minus that) and follow the
// last sub-block gain. Window switching with block type zero yields a
// single error word (type code, value 0, error and last set) and the parser
// then ignores bytes until the next first byte, as it does after reset and
// after the final count1 field. Rate: the field engine takes one bit per
// cycle while its output register can take a word; a derived region
// count or error word takes a step of its own and no bit. Once the parse
// halts, the unused rest of that byte is dropped whole, as is each ignored
// byte. A stalled field channel stalls the engine once its output register
// is full. A QUEUE_DEPTH-entry byte queue in front lets the upstream side
// burst while the engine works. There is no clearing pass after reset.
`default_nettype none

module mp3_side_info_parser
  import msi_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       byte_valid,
  output logic      byte_ready,
  input  in_word_t  byte_word,
  output logic      field_valid,
  input  wire       field_ready,
  output out_word_t field_word
);

  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_entry;
  eng_status_t  eng_status;

  // front: accept and queue bytes
  msi_byte_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (byte_valid),
    .push_ready (byte_ready),
    .push_word  (byte_word),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  // back: bit-serial parse and result register
  msi_field_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_entry     (q_entry),
    .field_valid (field_valid),
    .field_ready (field_ready),
    .field_word  (field_word),
    .status      (eng_status)
  );

`include "mp3_side_info_parser_assert.svh"

  // an accepted byte is queued or already in the engine
  `MSI_ASSERT_NEXT(a_byte_held, byte_valid && byte_ready, q_valid || eng_status.busy, "byte lost")

  // the error word leaves the parser halted
  `MSI_ASSERT_NOW(a_err_halts, field_valid && field_word.error, eng_status.halted, "error without halt")

  // a normal last word is the final count1 of granule 1
  `MSI_ASSERT_NOW(a_last_count1, field_valid && field_word.last && !field_word.error, field_word.field_code == CODE_COUNT1 && field_word.granule, "bad last word")

endmodule

`default_nettype wire

FILE: tb/sv/tb_mp3_side_info_parser.sv
`timescale 1ns / 100ps
// Self-checking bench for mp3_side_info_parser: directed rows, then random frames.
// Depends on msi_pkg for the word types, field codes and parse steps.

module tb_mp3_side_info_parser;
  import msi_pkg::*;

  localparam int PARSED_TARGET  = 350;  // bytes the parser actually consumes
  localparam int WATCHDOG_LIMIT = 1000; // cycles with no word moving on either side
  localparam int TAIL_CYCLES    = 64;   // byte queue plus engine, generously
  localparam int REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_QUARTER,
    RDY_MOSTLY
  } ready_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_word_t  byte_word = '0;
  logic      field_valid;
  logic      field_ready = 1'b0;
  out_word_t field_word;

  always #1 clk = ~clk;

  mp3_side_info_parser uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_word  (byte_word),
    .field_valid(field_valid),
    .field_ready(field_ready),
    .field_word (field_word)
  );

  // ---------------------------------------------------------------------------
  // Parser model: private copy of the bit accumulator and the parse position.
  // ---------------------------------------------------------------------------
  logic [11:0] sh_acc;
  logic [3:0]  sh_count;
  step_t       sh_step;
  logic        sh_gr;
  logic        sh_ch;
  logic [1:0]  sh_slot;
  logic        sh_mono;
  logic [1:0]  sh_kind;
  logic        sh_mixed;
  logic        sh_halted;

  out_word_t byte_fields[$];     // fields completed by the byte just taken
  out_word_t expected_fields[$]; // fields still owed by the block

  function automatic out_word_t make_field(field_code_t code, logic gr, logic ch,
                                           logic [1:0] slot, logic [11:0] value,
                                           logic err, logic last);
    out_word_t f;
    f.field_code = code;
    f.granule    = gr;
    f.channel    = ch;
    f.slot       = slot;
    f.value      = value;
    f.error      = err;
    f.last       = last;
    return f;
  endfunction

  function automatic void clear_parse_state();
    sh_acc    = '0;
    sh_count  = '0;
    sh_step   = STEP_IDLE;
    sh_gr     = 1'b0;
    sh_ch     = 1'b0;
    sh_slot   = '0;
    sh_mono   = 1'b0;
    sh_kind   = '0;
    sh_mixed  = 1'b0;
    sh_halted = 1'b1;
  endfunction

  function automatic int field_bits(step_t s);
    case (s)
      STEP_MDS:                 return 9;
      STEP_PRIV:                return sh_mono ? 5 : 3;
      STEP_SHARE, STEP_COMP,
      STEP_R0:                  return 4;
      STEP_LEN:                 return 12;
      STEP_BIG:                 return 9;
      STEP_GAIN:                return 8;
      STEP_TYPE:                return 2;
      STEP_WTABLE, STEP_NTABLE: return 5;
      STEP_SUBGAIN, STEP_R1:    return 3;
      default:                  return 1;
    endcase
  endfunction

  function automatic void emit_field(field_code_t code, logic [1:0] slot, logic [11:0] value,
                                     logic err, logic last);
    byte_fields.push_back(make_field(code, sh_gr, sh_ch, slot, value, err, last));
  endfunction

  // One field's bits are in; report it and move to the next position.
  function automatic void close_field(logic [11:0] v);
    logic [11:0] r0;
    logic        final_one;
    case (sh_step)
      STEP_MDS: begin
        emit_field(CODE_MDS, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_PRIV;
      end
      STEP_PRIV: begin
        sh_ch   = 1'b0;
        sh_step = STEP_SHARE;
      end
      STEP_SHARE: begin
        emit_field(CODE_SHARE, 2'd0, v, 1'b0, 1'b0);
        if (!sh_mono && sh_ch == 1'b0) begin
          sh_ch = 1'b1;
        end else begin
          sh_ch   = 1'b0;
          sh_gr   = 1'b0;
          sh_step = STEP_LEN;
        end
      end
      STEP_LEN: begin
        emit_field(CODE_LENGTH, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_BIG;
      end
      STEP_BIG: begin
        emit_field(CODE_BIG, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_GAIN;
      end
      STEP_GAIN: begin
        emit_field(CODE_GAIN, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_COMP;
      end
      STEP_COMP: begin
        emit_field(CODE_COMP, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_SWITCH;
      end
      STEP_SWITCH: begin
        emit_field(CODE_SWITCH, 2'd0, v, 1'b0, 1'b0);
        sh_slot = '0;
        if (v[0]) begin
          sh_step = STEP_TYPE;
        end else begin
          sh_kind  = '0;
          sh_mixed = 1'b0;
          sh_step  = STEP_NTABLE;
        end
      end
      STEP_TYPE: begin
        emit_field(CODE_TYPE, 2'd0, v, 1'b0, 1'b0);
        sh_kind = v[1:0];
        sh_step = STEP_MIXED;
      end
      STEP_MIXED: begin
        emit_field(CODE_MIXED, 2'd0, v, 1'b0, 1'b0);
        sh_mixed = v[0];
        sh_slot  = '0;
        sh_step  = STEP_WTABLE;
      end
      STEP_WTABLE: begin
        emit_field(CODE_TABLE, sh_slot, v, 1'b0, 1'b0);
        if (sh_slot >= 2'd1) begin
          sh_slot = '0;
          sh_step = STEP_SUBGAIN;
        end else begin
          sh_slot = sh_slot + 2'd1;
        end
      end
      STEP_SUBGAIN: begin
        emit_field(CODE_SUBGAIN, sh_slot, v, 1'b0, 1'b0);
        if (int'(sh_slot) + 1 >= SUBBLOCK_GAINS) begin
          sh_slot = '0;
          if (sh_kind == 2'd0) begin
            // switching with a normal block: one error word, then stop
            emit_field(CODE_TYPE, 2'd0, 12'd0, 1'b1, 1'b1);
            sh_halted = 1'b1;
            sh_step   = STEP_IDLE;
          end else begin
            r0 = (sh_kind == 2'd2 && !sh_mixed) ? 12'd8 : 12'd7;
            emit_field(CODE_REGION0, 2'd0, r0, 1'b0, 1'b0);
            emit_field(CODE_REGION1, 2'd0, 12'd20 - r0, 1'b0, 1'b0);
            sh_step = STEP_PRE;
          end
        end else begin
          sh_slot = sh_slot + 2'd1;
        end
      end
      STEP_NTABLE: begin
        emit_field(CODE_TABLE, sh_slot, v, 1'b0, 1'b0);
        if (sh_slot >= 2'd2) begin
          sh_slot = '0;
          sh_step = STEP_R0;
        end else begin
          sh_slot = sh_slot + 2'd1;
        end
      end
      STEP_R0: begin
        emit_field(CODE_REGION0, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_R1;
      end
      STEP_R1: begin
        emit_field(CODE_REGION1, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_PRE;
      end
      STEP_PRE: begin
        emit_field(CODE_PREFLAG, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_SCALE;
      end
      STEP_SCALE: begin
        emit_field(CODE_SCALE, 2'd0, v, 1'b0, 1'b0);
        sh_step = STEP_COUNT1;
      end
      STEP_COUNT1: begin
        final_one = (sh_mono || sh_ch) && sh_gr;
        emit_field(CODE_COUNT1, 2'd0, v, 1'b0, final_one);
        if (!sh_mono && sh_ch == 1'b0) begin
          sh_ch   = 1'b1;
          sh_step = STEP_LEN;
        end else if (sh_gr == 1'b0) begin
          sh_ch   = 1'b0;
          sh_gr   = 1'b1;
          sh_step = STEP_LEN;
        end else begin
          sh_halted = 1'b1;
          sh_step   = STEP_IDLE;
        end
      end
      default: begin
        sh_halted = 1'b1;
        sh_step   = STEP_IDLE;
      end
    endcase
  endfunction

  // Feed one byte through the model, MSB first; fields land in byte_fields.
  function automatic void parse_side_byte(in_word_t w);
    logic [11:0] v;
    int          b;
    byte_fields.delete();
    if (w.first_byte) begin
      clear_parse_state();
      sh_mono   = w.single_channel;
      sh_halted = 1'b0;
      sh_step   = STEP_MDS;
    end
    for (b = 7; b >= 0 && !sh_halted; b--) begin
      sh_acc   = {sh_acc[10:0], w.data_byte[b]};
      sh_count = sh_count + 4'd1;
      if (int'(sh_count) >= field_bits(sh_step)) begin
        v        = sh_acc;
        sh_acc   = '0;
        sh_count = '0;
        close_field(v);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. A count of -1 means the model supplies the fields; any
  // other count takes that many hand-written words from directed_fields.
  // ---------------------------------------------------------------------------
  in_word_t  directed_bytes[$];
  int        directed_counts[$];
  out_word_t directed_fields[$];

  function automatic void add_row(logic [7:0] d, logic first, logic mono, int n);
    in_word_t w;
    w.data_byte      = d;
    w.first_byte     = first;
    w.single_channel = mono;
    directed_bytes.push_back(w);
    directed_counts.push_back(n);
  endfunction

  // ---------------------------------------------------------------------------
  // Random frame builder: legal field layout with random contents.
  // ---------------------------------------------------------------------------
  bit       frame_bits[$];
  in_word_t frame_plan[$];

  function automatic void add_bits(int w, logic [11:0] v);
    int i;
    for (i = w - 1; i >= 0; i--) frame_bits.push_back(v[i]);
  endfunction

  // lean on all-zero and all-one values so field extremes show up often
  function automatic logic [11:0] pick_value(int w);
    logic [11:0] mask;
    mask = 12'hFFF >> (12 - w);
    case ($urandom_range(0, 5))
      0:       return 12'd0;
      1:       return mask;
      default: return 12'($urandom) & mask;
    endcase
  endfunction

  function automatic void build_frame();
    logic       mono;
    logic       sw;
    logic [1:0] kind;
    logic [7:0] d;
    in_word_t   w;
    int         g, c, k, j, nch, nbytes;
    bit         stopped;
    frame_bits.delete();
    frame_plan.delete();
    mono    = 1'($urandom_range(0, 1));
    nch     = mono ? 1 : 2;
    stopped = 1'b0;
    add_bits(9, pick_value(9));
    add_bits(mono ? 5 : 3, pick_value(5));
    for (c = 0; c < nch; c++) add_bits(4, pick_value(4));
    for (g = 0; g < 2; g++) begin
      for (c = 0; c < nch; c++) begin
        if (!stopped) begin
          add_bits(12, pick_value(12));
          add_bits(9, pick_value(9));
          add_bits(8, pick_value(8));
          add_bits(4, pick_value(4));
          sw = 1'($urandom_range(0, 1));
          add_bits(1, 12'(sw));
          if (sw) begin
            kind = ($urandom_range(0, 11) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            add_bits(2, 12'(kind));
            add_bits(1, 12'($urandom_range(0, 1)));
            for (k = 0; k < 2; k++) add_bits(5, pick_value(5));
            for (k = 0; k < SUBBLOCK_GAINS; k++) add_bits(3, pick_value(3));
            stopped = (kind == 2'd0);
          end else begin
            for (k = 0; k < 3; k++) add_bits(5, pick_value(5));
            add_bits(4, pick_value(4));
            add_bits(3, pick_value(3));
          end
          if (!stopped) begin
            add_bits(1, 12'($urandom_range(0, 1)));
            add_bits(1, 12'($urandom_range(0, 1)));
            add_bits(1, 12'($urandom_range(0, 1)));
          end
        end
      end
    end
    // random trailing bits up to the byte boundary
    while (frame_bits.size() % 8 != 0) frame_bits.push_back(1'($urandom_range(0, 1)));
    nbytes = frame_bits.size() / 8;
    // now and then cut the frame short; the next first byte must recover
    if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(1, nbytes - 1);
    for (k = 0; k < nbytes; k++) begin
      for (j = 0; j < 8; j++) d[7 - j] = frame_bits[k * 8 + j];
      w.data_byte      = d;
      w.first_byte     = (k == 0);
      w.single_channel = (k == 0) ? mono : 1'($urandom_range(0, 1));
      frame_plan.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Byte side driver: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left   = 0;
  int bytes_sent   = 0;
  int parsed_bytes = 0;
  int frames_sent  = 0;

  task automatic send_word(in_word_t w, int n_typed);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_word  <= w;
    do @(posedge clk); while (!byte_ready);
    // bytes dropped while halted are not counted toward the target
    if (w.first_byte || !sh_halted) parsed_bytes++;
    if (w.first_byte) frames_sent++;
    bytes_sent++;
    parse_side_byte(w);
    if (n_typed < 0) begin
      foreach (byte_fields[i]) expected_fields.push_back(byte_fields[i]);
    end else begin
      repeat (n_typed) expected_fields.push_back(directed_fields.pop_front());
    end
  endtask

  // hold off the byte side until every owed field has come out
  task automatic wait_for_fields();
    byte_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_fields.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Field side: stall pattern, checker and watchdog.
  // ---------------------------------------------------------------------------
  ready_mode_t ready_mode = RDY_ALWAYS;
  logic [7:0]  ready_tick = '0;
  int          fields_seen = 0;
  int          error_words = 0;
  int          frame_ends  = 0;
  int          bad_fields  = 0;
  int          quiet_cycles = 0;
  out_word_t   owed;

  function automatic string show(out_word_t f);
    return $sformatf("code %0d gr %0d ch %0d slot %0d value %0d err %0d last %0d",
                     f.field_code, f.granule, f.channel, f.slot, f.value, f.error, f.last);
  endfunction

  function automatic void log_bad(string why, out_word_t exp_f, out_word_t got_f);
    bad_fields++;
    if (bad_fields <= REPORT_LIMIT)
      $display("%0t: %s\n  expected %s\n  actual   %s", $realtime, why, show(exp_f),
               show(got_f));
  endfunction

  always @(posedge clk) begin
    if (!rst && field_valid && field_ready) begin
      fields_seen++;
      if (field_word.error) error_words++;
      if (field_word.last) frame_ends++;
      if (expected_fields.size() == 0) begin
        log_bad("field word with nothing owed", '0, field_word);
      end else begin
        owed = expected_fields.pop_front();
        if (field_word.field_code !== owed.field_code || field_word.granule !== owed.granule ||
            field_word.channel !== owed.channel || field_word.slot !== owed.slot ||
            field_word.value !== owed.value || field_word.error !== owed.error ||
            field_word.last !== owed.last)
          log_bad("field word mismatch", owed, field_word);
      end
    end
    // receiver stall: a randomly redrawn mode, one of which never stalls
    ready_tick <= ready_tick + 8'd1;
    if (ready_tick % 40 == 0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS:  field_ready <= 1'b1;
      RDY_COIN:    field_ready <= 1'($urandom_range(0, 1));
      RDY_QUARTER: field_ready <= (ready_tick[1:0] == 2'd0);
      default:     field_ready <= ($urandom_range(0, 6) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (field_valid && field_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d fields owed", quiet_cycles,
                 expected_fields.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_parse_state();

    // Parser sits halted out of reset: a plain byte gives nothing.
    add_row(8'hA5, 1'b0, 1'b0, 0);
    // Stereo frame of all ones: main data start tops out at 511, the first
    // share word is all ones, and the mono flag on a later byte is ignored.
    add_row(8'hFF, 1'b1, 1'b0, 0);
    add_row(8'hFF, 1'b0, 1'b1, 2);
    directed_fields.push_back(make_field(CODE_MDS, 1'b0, 1'b0, 2'd0, 12'd511, 1'b0, 1'b0));
    directed_fields.push_back(make_field(CODE_SHARE, 1'b0, 1'b0, 2'd0, 12'd15, 1'b0, 1'b0));
    // Restart mid-frame into a mono frame of zeros with only the switch bit
    // set: block type 0 under window switching ends in the error word right
    // after the third sub-block gain, in the tenth byte.
    add_row(8'h00, 1'b1, 1'b1, -1);
    add_row(8'h00, 1'b0, 1'b0, -1);
    add_row(8'h00, 1'b0, 1'b1, -1);
    add_row(8'h00, 1'b0, 1'b0, -1);
    add_row(8'h00, 1'b0, 1'b0, -1);
    add_row(8'h00, 1'b0, 1'b0, -1);
    add_row(8'h10, 1'b0, 1'b0, -1);
    add_row(8'h00, 1'b0, 1'b0, -1);
    add_row(8'h00, 1'b0, 1'b0, -1);
    add_row(8'h00, 1'b0, 1'b0, 2);
    directed_fields.push_back(make_field(CODE_SUBGAIN, 1'b0, 1'b0, 2'd2, 12'd0, 1'b0, 1'b0));
    directed_fields.push_back(make_field(CODE_TYPE, 1'b0, 1'b0, 2'd0, 12'd0, 1'b1, 1'b1));
    // halted after the error: ignored until the next first byte
    add_row(8'hFF, 1'b0, 1'b0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bytes[i]) send_word(directed_bytes[i], directed_counts[i]);
    wait_for_fields();

    // Random frames, with some noise bytes between them and an occasional
    // full drain so the block also restarts from a quiet output side.
    while (parsed_bytes < PARSED_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          in_word_t noise;
          noise.data_byte      = 8'($urandom);
          noise.first_byte     = 1'b0;
          noise.single_channel = 1'($urandom_range(0, 1));
          send_word(noise, -1);
        end
      end
      build_frame();
      foreach (frame_plan[i]) send_word(frame_plan[i], -1);
      if (frames_sent % 5 == 0) wait_for_fields();
    end

    byte_valid <= 1'b0;
    do @(posedge clk); while (expected_fields.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes (%0d parsed) over %0d frame starts, mono and stereo.",
             bytes_sent, parsed_bytes, frames_sent);
    $display("Checked %0d fields: %0d frame ends, %0d error words, %0d bad.",
             fields_seen, frame_ends, error_words, bad_fields);
    if (bad_fields == 0 && expected_fields.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/msi_pkg.sv
rtl/core/msi_byte_queue.sv
rtl/core/msi_field_engine.sv
rtl/core/mp3_side_info_parser.sv
tb/sv/tb_mp3_side_info_parser.sv
